FILE: rtl/positional_list_prev_greater_search_core_assert.svh
// Assertion macros used by the sequencer of the list search core.
`ifndef POSITIONAL_LIST_PREV_GREATER_SEARCH_CORE_ASSERT_SVH
`define POSITIONAL_LIST_PREV_GREATER_SEARCH_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PLPGS_ASSERT_NOW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// Check that a cause is followed by an effect in the next cycle.
`define PLPGS_ASSERT_NEXT(label, clk, rst, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("%m: check failed");

`endif

FILE: rtl/plpgs_pkg.sv
// ----------------------------------------------------------------------------
// plpgs_pkg
// Shared types and constants of the ordered list search core.
// ----------------------------------------------------------------------------
package plpgs_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int POS_BITS       = 11;
  localparam int DATA_BITS      = 32;
  localparam int INDEX_BITS     = 10;
  localparam int STATUS_BITS    = 3;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_Q_BASE,
    S_Q_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [INDEX_BITS-1:0] index;
  } res_t;

endpackage

FILE: rtl/plpgs_ram.sv
// ----------------------------------------------------------------------------
// plpgs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plpgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/plpgs_seq.sv
// ----------------------------------------------------------------------------
// plpgs_seq
// Sequencer: shifts entries for inserts and walks down for queries,
// one entry per cycle.
// ----------------------------------------------------------------------------
`include "positional_list_prev_greater_search_core_assert.svh"

module plpgs_seq #(
  parameter int DEPTH      = plpgs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = plpgs_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           kind,
  input  logic [plpgs_pkg::POS_BITS-1:0] position,
  input  logic [plpgs_pkg::DATA_BITS-1:0] value,
  output logic                           ready,
  output plpgs_pkg::res_t                res,
  input  logic                           res_take,
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output logic [VALUE_BITS-1:0]          ram_wdata,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  input  logic [VALUE_BITS-1:0]          ram_rdata
);

  import plpgs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;
  localparam int SW = VALUE_BITS + 2;

  state_t                 state;
  state_t                 state_next;
  logic [CW-1:0]          count;
  logic [AW-1:0]          addr;
  logic [AW-1:0]          ins_pos;
  logic [VALUE_BITS-1:0]  arg;
  logic signed [SW-1:0]   want;
  status_t                res_status;
  logic [INDEX_BITS-1:0]  res_index;

  logic                   acc;
  logic                   is_query;
  logic                   full;
  logic                   pos_ge_count;
  logic [PW-1:0]          pos_ext;
  logic [PW-1:0]          count_ext;
  logic [AW-1:0]          pos_clamp;
  logic [AW-1:0]          last_addr;
  logic [VALUE_BITS+DATA_BITS-1:0] val_ext;
  logic [VALUE_BITS-1:0]  val_n;
  logic signed [SW-1:0]   rd_s;
  logic signed [SW-1:0]   arg_s;
  logic                   hit;
  logic [AW+INDEX_BITS-1:0] idx_ext;

  assign acc          = req_valid && (state == S_IDLE);
  assign is_query     = (kind == KIND_QUERY);
  assign full         = (count == CW'(DEPTH));
  assign pos_ext      = PW'(position);
  assign count_ext    = PW'(count);
  assign pos_ge_count = (pos_ext >= count_ext);
  assign pos_clamp    = pos_ge_count ? AW'(count) : AW'(position);
  assign last_addr    = AW'(count - 1'b1);
  assign val_ext      = {{VALUE_BITS{1'b0}}, value};
  assign val_n        = val_ext[VALUE_BITS-1:0];
  assign rd_s         = $signed({{2{ram_rdata[VALUE_BITS-1]}}, ram_rdata});
  assign arg_s        = $signed({{2{arg[VALUE_BITS-1]}}, arg});
  assign hit          = (rd_s >= want);
  assign idx_ext      = {{INDEX_BITS{1'b0}}, addr};

  assign ready      = (state == S_IDLE);
  assign res.valid  = (state == S_DONE);
  assign res.status = res_status;
  assign res.index  = res_index;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (is_query) begin
            state_next = pos_ge_count ? S_DONE : S_Q_BASE;
          end else if (full) begin
            state_next = S_DONE;
          end else if (pos_ge_count) begin
            state_next = S_INS_WRITE;
          end else begin
            state_next = S_INS_SHIFT;
          end
        end
      end
      S_INS_SHIFT: begin
        if (addr == ins_pos) begin
          state_next = S_INS_WRITE;
        end
      end
      S_INS_WRITE: state_next = S_DONE;
      S_Q_BASE: begin
        if (addr == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        if (hit || (addr == '0)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr + 1'b1;
    ram_wdata = ram_rdata;
    ram_raddr = addr - 1'b1;
    case (state)
      S_IDLE: begin
        ram_raddr = is_query ? AW'(position) : last_addr;
      end
      S_INS_SHIFT: begin
        // move entry up by one, fetch the one below
        ram_we = 1'b1;
      end
      S_INS_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = ins_pos;
        ram_wdata = arg;
      end
      S_Q_BASE, S_Q_SCAN, S_DONE: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_INS_WRITE) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          arg       <= val_n;
          ins_pos   <= pos_clamp;
          addr      <= is_query ? AW'(position) : last_addr;
          res_index <= '0;
          if (is_query) begin
            res_status <= ST_RANGE;
          end else if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_INSERTED;
          end
        end
      end
      S_INS_SHIFT: begin
        if (addr != ins_pos) begin
          addr <= addr - 1'b1;
        end
      end
      S_Q_BASE: begin
        // threshold is formed wide so it never wraps
        want       <= rd_s + arg_s + SW'(1);
        res_status <= ST_NOT_FOUND;
        addr       <= addr - 1'b1;
      end
      S_Q_SCAN: begin
        if (hit) begin
          res_status <= ST_FOUND;
          res_index  <= idx_ext[INDEX_BITS-1:0];
        end else if (addr != '0) begin
          addr <= addr - 1'b1;
        end
      end
      S_INS_WRITE, S_DONE: begin
        addr <= addr;
      end
      default: addr <= addr;
    endcase
  end

  `PLPGS_ASSERT_NOW(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `PLPGS_ASSERT_NOW(a_write_in_list, clk, rst, !ram_we || (CW'(ram_waddr) <= count))
  `PLPGS_ASSERT_NOW(a_scan_in_list, clk, rst,
    !((state == S_Q_BASE) || (state == S_Q_SCAN)) || (CW'(addr) < count))
  `PLPGS_ASSERT_NEXT(a_count_steady, clk, rst, state != S_INS_WRITE, $stable(count))

endmodule

FILE: rtl/positional_list_prev_greater_search_core.sv
// ----------------------------------------------------------------------------
// positional_list_prev_greater_search_core
// Ordered list of signed values with insert and previous-greater search.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries kind, position and value.
//   kind insert places value at position (clamped to the end), shifting later
//   entries up; kind query returns the largest index below position whose
//   entry is at least entry[position] + value + 1.
//   Response channel (rsp_valid/rsp_stall) carries status and index, one
//   item per request.
//   One item is worked at a time; req_stall is high while it is in flight.
//   An insert at p first shifts the count - p entries at and above p up by one;
//   a query at p reads entry p and then scans at most p entries below it: the
//   single read port of the entry RAM moves one entry per cycle. Errors (full,
//   out of range) skip the walk and go straight to the result.
//   A stalled response holds in its register; the finished result then waits
//   in the sequencer and the next request is held off until it moves.
//   Reset empties the list at once; the RAM is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module positional_list_prev_greater_search_core #(
  parameter int DEPTH      = plpgs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = plpgs_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              kind,
  input  logic [plpgs_pkg::POS_BITS-1:0]    position,
  input  logic [plpgs_pkg::DATA_BITS-1:0]   value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [plpgs_pkg::STATUS_BITS-1:0] status,
  output logic [plpgs_pkg::INDEX_BITS-1:0]  index
);

  import plpgs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  ready;
  res_t                  res;
  logic                  res_take;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  status_t               rsp_status;
  logic [INDEX_BITS-1:0] rsp_index;

  assign req_stall = !ready;
  assign res_take  = res.valid && (!rsp_valid || !rsp_stall);
  assign status    = rsp_status;
  assign index     = rsp_index;

  plpgs_seq #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .ready     (ready),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  plpgs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Response register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp_status <= res.status;
      rsp_index  <= res.index;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list search core.
// Inserts and previous-greater queries are run against a behavioral copy of
// the list. Every response is compared in order with the predicted answer.
// The request side idles and the response side stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import plpgs_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int MAX_IDLE   = 10;
  localparam int MIXED_OPS  = 400;
  localparam int DEEP_OPS   = 160;
  localparam int HALF_CLK   = 10;

  typedef struct packed {
    kind_t                 kind;
    logic [POS_BITS-1:0]   pos;
    logic [DATA_BITS-1:0]  val;
  } list_op_t;

  typedef struct packed {
    status_t               st;
    logic [INDEX_BITS-1:0] idx;
  } answer_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  logic                   kind      = 1'b0;
  logic [POS_BITS-1:0]    position  = '0;
  logic [DATA_BITS-1:0]   value     = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic [INDEX_BITS-1:0]  index;

  positional_list_prev_greater_search_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .index     (index)
  );

  always #(HALF_CLK) clk = ~clk;

  // Behavioral list
  logic signed [DATA_BITS-1:0] list_vals [LIST_DEPTH];
  int unsigned                 list_len = 0;

  list_op_t ops_q[$];
  answer_t  answers_q[$];
  int       gen_len     = 0;
  int       n_total     = 0;
  int       n_accepted  = 0;
  int       errors      = 0;
  int       tally [5]   = '{default: 0};
  longint   cycles      = 0;
  longint   cycle_limit = 0;

  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;
  logic calm      = 1'b0;
  int   req_idle  = 0;
  int   rsp_wait  = 0;

  function automatic void apply_list_op(input kind_t op, input logic [POS_BITS-1:0] pos,
                                        input logic [DATA_BITS-1:0] val,
                                        output status_t st,
                                        output logic [INDEX_BITS-1:0] idx);
    int unsigned p;
    int unsigned i;
    longint      want;
    bit          hit;
    p   = pos;
    idx = '0;
    hit = 1'b0;
    if (op == KIND_INSERT) begin
      if (list_len >= LIST_DEPTH) begin
        st = ST_FULL;
      end else begin
        if (p > list_len) p = list_len;
        for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
        list_vals[p] = val;
        list_len++;
        st = ST_INSERTED;
      end
    end else if (p >= list_len) begin
      st = ST_RANGE;
    end else begin
      // form the threshold wide so it cannot wrap
      want = longint'(list_vals[p]) + longint'($signed(val)) + 1;
      st   = ST_NOT_FOUND;
      i    = p;
      while (i > 0 && !hit) begin
        i--;
        if (longint'(list_vals[i]) >= want) begin
          hit = 1'b1;
          st  = ST_FOUND;
          idx = i[INDEX_BITS-1:0];
        end
      end
    end
  endfunction

  function automatic void push_op(input kind_t k, input int pos, input logic [31:0] v);
    list_op_t op;
    op.kind = k;
    op.pos  = pos[POS_BITS-1:0];
    op.val  = v;
    ops_q   = {ops_q, op};
    if (k == KIND_INSERT && gen_len < LIST_DEPTH) gen_len++;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 30) return $urandom;
    return 32'($urandom_range(0, 128)) - 32'd64;
  endfunction

  function automatic logic [31:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (r < 30) return $urandom;
    if (r < 50) return 32'($urandom_range(0, 400)) - 32'd200;
    return 32'($urandom_range(0, 16)) - 32'd8;
  endfunction

  function automatic int draw_idle();
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want_v);
    errors++;
  endtask

  // Request driver: hold an item until taken, then idle a drawn number of cycles
  always @(negedge clk) begin
    list_op_t op;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // hold
    end else begin
      if (req_valid) req_idle = draw_idle();
      if (req_idle != 0) begin
        req_idle--;
        req_valid <= 1'b0;
      end else if (ops_q.size() != 0) begin
        op = ops_q.pop_front();
        req_valid <= 1'b1;
        kind      <= op.kind;
        position  <= op.pos;
        value     <= op.val;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response stall: a drawn number of stalled cycles per item
  always @(negedge clk) begin
    if (rsp_taken) rsp_wait = draw_idle();
    rsp_stall <= (rsp_wait != 0);
    if (rsp_valid === 1'b1 && rsp_wait != 0) rsp_wait--;
  end

  // Check responses, then predict newly accepted requests
  always @(posedge clk) begin
    answer_t want;
    status_t st;
    logic [INDEX_BITS-1:0] ix;
    cycles++;
    if ($urandom_range(0, 149) == 0) calm <= !calm;
    if (rst) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
      if (rsp_valid && !rsp_stall) begin
        if (answers_q.size() == 0) begin
          report_mismatch("response with no request waiting", 32'(status), 32'd0);
        end else begin
          want = answers_q.pop_front();
          tally[int'(want.st)]++;
          if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
          if (index !== want.idx) report_mismatch("index", 32'(index), 32'(want.idx));
        end
      end
      if (req_valid && !req_stall) begin
        apply_list_op(kind_t'(kind), position, value, st, ix);
        want.st   = st;
        want.idx  = ix;
        answers_q = {answers_q, want};
        n_accepted++;
      end
    end
    if (cycles > cycle_limit) begin
      $display("Timeout after %0d cycles, %0d of %0d items taken", cycles, n_accepted,
               n_total);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r;
    int deep_lo;
    // Directed: empty list, extreme values and offsets, boundaries of the search
    push_op(KIND_QUERY, 0, 32'd0);
    push_op(KIND_INSERT, 0, 32'h7fff_ffff);
    push_op(KIND_INSERT, 2047, 32'h8000_0000);
    push_op(KIND_INSERT, 0, 32'd5);
    push_op(KIND_INSERT, 1, 32'hffff_ffff);
    push_op(KIND_QUERY, 3, 32'h7fff_ffff);
    push_op(KIND_QUERY, 3, 32'h8000_0000);
    push_op(KIND_QUERY, 2, 32'h7fff_ffff);
    push_op(KIND_QUERY, 2, 32'h8000_0000);
    push_op(KIND_QUERY, 0, 32'h8000_0000);
    push_op(KIND_QUERY, 4, 32'd0);
    push_op(KIND_QUERY, 1024, 32'd0);
    push_op(KIND_QUERY, 2047, 32'hffff_ffff);
    push_op(KIND_INSERT, 1024, 32'd0);
    push_op(KIND_QUERY, 1, 32'hffff_fff9);
    push_op(KIND_QUERY, 1, 32'd5);
    push_op(KIND_QUERY, 1, 32'd6);

    // Mixed traffic while the list grows
    repeat (MIXED_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 99) < 85) push_op(KIND_INSERT, $urandom_range(0, gen_len),
                                                pick_value());
        else push_op(KIND_INSERT, $urandom_range(0, 2047), pick_value());
      end else if (gen_len > 0 && $urandom_range(0, 99) < 85) begin
        push_op(KIND_QUERY, $urandom_range(0, gen_len - 1), pick_offset());
      end else begin
        push_op(KIND_QUERY, $urandom_range(0, 2047), pick_offset());
      end
    end

    // Scattered inserts, queries anywhere and deep queries near the end of the list
    repeat (DEEP_OPS) begin
      r       = $urandom_range(0, 99);
      deep_lo = (gen_len > 64) ? gen_len - 64 : 0;
      if (r < 35) push_op(KIND_INSERT, $urandom_range(0, 2047), pick_value());
      else if (r < 45) push_op(KIND_QUERY, $urandom_range(0, 2047), pick_offset());
      else if (r < 70) push_op(KIND_QUERY, $urandom_range(deep_lo, gen_len - 1),
                               pick_offset());
      else push_op(KIND_QUERY, $urandom_range(0, gen_len - 1), pick_offset());
    end

    n_total     = ops_q.size();
    cycle_limit = longint'(n_total) * (LIST_DEPTH + 2 * MAX_IDLE + 8) * 4 + 10000;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total || answers_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Ran %0d list operations: %0d inserted, %0d rejected as full, %0d found,",
             n_total, tally[ST_INSERTED], tally[ST_FULL], tally[ST_FOUND]);
    $display("  %0d not found, %0d out of range; the list grew to %0d entries",
             tally[ST_NOT_FOUND], tally[ST_RANGE], list_len);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: positional_list_prev_greater_search_core.f
+incdir+rtl
rtl/plpgs_pkg.sv
rtl/plpgs_ram.sv
rtl/plpgs_seq.sv
rtl/positional_list_prev_greater_search_core.sv
dv/tb.sv
